FILE: hw/rtl/mfr_pkg.sv
// Package for the monochrome frame raster engine: constants, codes and transfer types.
`timescale 1ns / 1ps
package mfr_pkg;

  localparam int unsigned ROW_WORDS   = 20;
  localparam int unsigned SCREEN_ROWS = 400;
  localparam int unsigned ROW_PIXELS  = ROW_WORDS * 32;
  localparam int unsigned STORE_WORDS = ROW_WORDS * SCREEN_ROWS;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam int unsigned WIDX_W      = ($clog2(ROW_WORDS) > 0) ? $clog2(ROW_WORDS) : 1;

  typedef enum logic [2:0] {
    REQ_FILL      = 3'd0,
    REQ_CLEAR     = 3'd1,
    REQ_BLIT      = 3'd2,
    REQ_BLIT_INV  = 3'd3,
    REQ_SET       = 3'd4,
    REQ_READ      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    SZ_8      = 2'd0,
    SZ_16     = 2'd1,
    SZ_32     = 2'd2,
    SZ_UNUSED = 2'd3
  } sprite_size_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_CLR,
    OP_BLIT,
    OP_READ
  } op_kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_MODIFY,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  x_pos;
    logic [8:0]  y_pos;
    logic [9:0]  span_width;
    logic [8:0]  row_offset;
    logic [1:0]  sprite_size;
    logic [31:0] sprite_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
  } out_t;

  // One classified row operation as handed from the front to the back.
  typedef struct packed {
    op_kind_e            kind;
    logic                status;
    logic [8:0]          row;
    logic [WIDX_W-1:0]   wfirst;
    logic [WIDX_W-1:0]   wlast;
    logic [4:0]          lo_bit;
    logic [4:0]          hi_bit;
    logic                second_row;
    logic [63:0]         pat_v;
  } op_t;

endpackage

FILE: hw/rtl/mfr_front.sv
// Front end: accepts requests, checks bounds and turns each into a word-range operation.
`timescale 1ns / 1ps
module mfr_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mfr_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  input  logic          clearing_i,
  output logic          push_o,
  output mfr_pkg::op_t  op_o
);

  logic [9:0]  row;
  logic [10:0] trow2;
  logic [10:0] trow;
  logic        x_bad;
  logic        y_bad;
  logic [11:0] fill_end;
  logic [2:0]  ub_log;
  logic [11:0] clr_start;
  logic [11:0] clr_span;
  logic [11:0] clr_end;
  logic [11:0] span_lo;
  logic [11:0] span_hi;
  logic [11:0] hi_clip;
  logic [31:0] pat_mask;
  logic [31:0] pat;
  logic [6:0]  pat_shift;
  logic [mfr_pkg::WIDX_W-1:0] xw;

  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    row       = {1'b0, in_data_i.y_pos} + {1'b0, in_data_i.row_offset};
    trow2     = {2'b0, in_data_i.y_pos} + {1'b0, in_data_i.row_offset, 1'b0};
    trow      = (in_data_i.sprite_size == mfr_pkg::SZ_32) ? trow2 : {1'b0, row};
    x_bad     = 32'(in_data_i.x_pos) >= mfr_pkg::ROW_PIXELS;
    y_bad     = 32'(in_data_i.y_pos) >= mfr_pkg::SCREEN_ROWS;
    xw        = mfr_pkg::WIDX_W'(in_data_i.x_pos >> 5);

    fill_end  = {2'b0, in_data_i.x_pos} + {2'b0, in_data_i.span_width} - 12'd1;

    // Clear works on whole units whose size follows from the span width.
    if (in_data_i.span_width <= 10'd8) begin
      ub_log = 3'd3;
    end else if (in_data_i.span_width <= 10'd32) begin
      ub_log = 3'd4;
    end else begin
      ub_log = 3'd5;
    end
    clr_start = {2'b0, in_data_i.x_pos} & ~((12'd1 << ub_log) - 12'd1);
    clr_span  = (({2'b0, in_data_i.span_width} >> ub_log) + 12'd1) << ub_log;
    clr_end   = clr_start + clr_span - 12'd1;

    unique case (in_data_i.sprite_size)
      mfr_pkg::SZ_8:  pat_mask = 32'h0000_00FF;
      mfr_pkg::SZ_16: pat_mask = 32'h0000_FFFF;
      default:        pat_mask = 32'hFFFF_FFFF;
    endcase
    if (in_data_i.req_type == mfr_pkg::REQ_BLIT_INV) begin
      pat = ~in_data_i.sprite_bits & pat_mask;
    end else begin
      pat = in_data_i.sprite_bits & pat_mask;
    end
    unique case (in_data_i.sprite_size)
      mfr_pkg::SZ_8:  pat_shift = 7'd56 - {2'b0, in_data_i.x_pos[4:0]};
      mfr_pkg::SZ_16: pat_shift = 7'd48 - {2'b0, in_data_i.x_pos[4:0]};
      default:        pat_shift = 7'd32 - {2'b0, in_data_i.x_pos[4:0]};
    endcase

    span_lo = {2'b0, in_data_i.x_pos};
    span_hi = {2'b0, in_data_i.x_pos};

    op_o            = '0;
    op_o.kind       = mfr_pkg::OP_NONE;
    op_o.status     = 1'b0;
    op_o.row        = row[8:0];
    op_o.pat_v      = {32'h0, pat} << pat_shift;
    op_o.second_row = 1'b0;

    unique case (in_data_i.req_type)
      mfr_pkg::REQ_BLIT, mfr_pkg::REQ_BLIT_INV: begin
        op_o.row = trow[8:0];
        if (x_bad || y_bad || 32'(trow) >= mfr_pkg::SCREEN_ROWS) begin
          op_o.status = 1'b1;
        end else if (in_data_i.sprite_size != mfr_pkg::SZ_UNUSED) begin
          op_o.kind       = mfr_pkg::OP_BLIT;
          op_o.second_row = (in_data_i.sprite_size == mfr_pkg::SZ_32) &&
                            (32'(trow) + 32'd1 < mfr_pkg::SCREEN_ROWS);
        end
      end
      mfr_pkg::REQ_FILL, mfr_pkg::REQ_CLEAR, mfr_pkg::REQ_SET, mfr_pkg::REQ_READ: begin
        if (x_bad || y_bad || 32'(row) >= mfr_pkg::SCREEN_ROWS) begin
          op_o.status = 1'b1;
        end else begin
          unique case (in_data_i.req_type)
            mfr_pkg::REQ_FILL: begin
              if (in_data_i.span_width != 10'd0) begin
                op_o.kind = mfr_pkg::OP_SET;
                span_hi   = fill_end;
              end
            end
            mfr_pkg::REQ_CLEAR: begin
              op_o.kind = mfr_pkg::OP_CLR;
              span_lo   = clr_start;
              span_hi   = clr_end;
            end
            mfr_pkg::REQ_SET: begin
              op_o.kind = mfr_pkg::OP_SET;
            end
            default: begin
              op_o.kind = mfr_pkg::OP_READ;
            end
          endcase
        end
      end
      default: begin
        op_o.status = 1'b1;
      end
    endcase

    hi_clip = (32'(span_hi) >= mfr_pkg::ROW_PIXELS) ? 12'(mfr_pkg::ROW_PIXELS - 1) : span_hi;

    if (op_o.kind == mfr_pkg::OP_BLIT) begin
      op_o.wfirst = xw;
      op_o.wlast  = (32'(xw) + 32'd1 < mfr_pkg::ROW_WORDS) ? xw + mfr_pkg::WIDX_W'(1) : xw;
      op_o.lo_bit = 5'd0;
      op_o.hi_bit = 5'd31;
    end else begin
      op_o.wfirst = mfr_pkg::WIDX_W'(span_lo >> 5);
      op_o.wlast  = mfr_pkg::WIDX_W'(hi_clip >> 5);
      op_o.lo_bit = span_lo[4:0];
      op_o.hi_bit = hi_clip[4:0];
    end
  end

endmodule

FILE: hw/rtl/mfr_queue.sv
// Two-entry queue of classified operations between the front and the back.
`timescale 1ns / 1ps
module mfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfr_pkg::op_t  push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mfr_pkg::op_t  pop_data_o
);

  mfr_pkg::op_t entry_q [2];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i && !full_o) begin
      wptr_d  = ~wptr_q;
      count_d = count_d + 2'd1;
    end
    if (pop_i && !empty_o) begin
      rptr_d  = ~rptr_q;
      count_d = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/mfr_back.sv
// Back end: frame store and the read-modify-write sequencer that carries out operations.
`timescale 1ns / 1ps
module mfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  mfr_pkg::op_t  q_data_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mfr_pkg::out_t out_data_o
);

  localparam int unsigned AW = mfr_pkg::ADDR_W;
  localparam int unsigned WW = mfr_pkg::WIDX_W;

  logic [31:0] mem [mfr_pkg::STORE_WORDS];

  mfr_pkg::bk_state_e state_q, state_d;
  mfr_pkg::op_t       cur_q, cur_d;
  logic [WW-1:0]      w_q, w_d;
  logic [8:0]         row_q, row_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic               second_q, second_d;
  logic [31:0]        rdata_q;
  logic [31:0]        res_data_q, res_data_d;
  logic               out_valid_q, out_valid_d;
  mfr_pkg::out_t      out_q, out_d;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic [AW-1:0]      word_addr;
  logic [4:0]         bit_a;
  logic [4:0]         bit_b;
  logic [31:0]        mask;

  assign clearing_o  = state_q == mfr_pkg::BK_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    word_addr = AW'({4'b0, row_q}) * AW'(mfr_pkg::ROW_WORDS) + AW'(w_q);
    bit_a     = (w_q == cur_q.wfirst) ? cur_q.lo_bit : 5'd0;
    bit_b     = (w_q == cur_q.wlast) ? cur_q.hi_bit : 5'd31;
    mask      = (32'hFFFF_FFFF >> bit_a) & (32'hFFFF_FFFF << (5'd31 - bit_b));
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    w_d         = w_q;
    row_d       = row_q;
    clr_addr_d  = clr_addr_q;
    second_d    = second_q;
    res_data_d  = res_data_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = word_addr;
    mem_wdata   = rdata_q;

    unique case (state_q)
      mfr_pkg::BK_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = 32'h0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (32'(clr_addr_q) == mfr_pkg::STORE_WORDS - 1) begin
          state_d = mfr_pkg::BK_IDLE;
        end
      end
      mfr_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o      = 1'b1;
          cur_d      = q_data_i;
          w_d        = q_data_i.wfirst;
          row_d      = q_data_i.row;
          second_d   = q_data_i.second_row;
          res_data_d = 32'h0;
          if (q_data_i.kind == mfr_pkg::OP_NONE) begin
            state_d = mfr_pkg::BK_DONE;
          end else begin
            state_d = mfr_pkg::BK_READ;
          end
        end
      end
      mfr_pkg::BK_READ: begin
        state_d = mfr_pkg::BK_MODIFY;
      end
      mfr_pkg::BK_MODIFY: begin
        if (cur_q.kind == mfr_pkg::OP_READ) begin
          res_data_d = rdata_q;
          state_d    = mfr_pkg::BK_DONE;
        end else begin
          mem_we = 1'b1;
          unique case (cur_q.kind)
            mfr_pkg::OP_CLR:  mem_wdata = rdata_q & ~mask;
            mfr_pkg::OP_BLIT: mem_wdata = rdata_q |
                                ((w_q == cur_q.wfirst) ? cur_q.pat_v[63:32] : cur_q.pat_v[31:0]);
            default:          mem_wdata = rdata_q | mask;
          endcase
          if (w_q == cur_q.wlast) begin
            if (second_q) begin
              // A 32-bit sprite repeats on the row below.
              second_d = 1'b0;
              row_d    = row_q + 9'd1;
              w_d      = cur_q.wfirst;
              state_d  = mfr_pkg::BK_READ;
            end else begin
              state_d = mfr_pkg::BK_DONE;
            end
          end else begin
            w_d     = w_q + WW'(1);
            state_d = mfr_pkg::BK_READ;
          end
        end
      end
      mfr_pkg::BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.read_data = res_data_q;
          out_d.status    = cur_q.status;
          state_d         = mfr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = mfr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfr_pkg::BK_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    w_q        <= w_d;
    row_q      <= row_d;
    res_data_q <= res_data_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[word_addr];
  end

endmodule

FILE: hw/rtl/mono_frame_raster_ops.sv
// Top level of the monochrome frame raster engine.
`timescale 1ns / 1ps
// Raster engine over a 640x400 one-bit frame store (20 words of 32 bits per row).
// Requests arrive on the input channel (in_valid_i, in_stall_o, in_data_i); every
// request yields exactly one result on the output channel (out_valid_o,
// out_stall_i, out_data_o) carrying the read word and the rejection status.
// A front end checks bounds and reduces each request to a range of words with
// edge masks or a two-word sprite pattern; a two-entry queue decouples it from
// the back end, which updates the store by read-modify-write over one port.
// Each touched word passes through a read and a modify state, and each request
// also through an idle and a done state; a full-row fill touches 20 words, a
// pixel set or read one, a two-word blit two, and a doubled 32-bit sprite row
// up to four. The back end works on one request at a time, taking the next
// from the queue only when idle. After reset it zeroes all 8000 store words,
// one word per cycle, and stalls the input channel meanwhile. A stalled result
// waits in the output register; one more request can finish behind it and two
// more wait in the queue before the input channel stalls.
module mono_frame_raster_ops (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mfr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mfr_pkg::out_t out_data_o
);

  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_empty;
  logic         clearing;
  mfr_pkg::op_t push_op;
  mfr_pkg::op_t head_op;

  mfr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .op_o       (push_op)
  );

  mfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (head_op)
  );

  mfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (head_op),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sim/mono_frame_raster_ops_tb.sv
// Testbench for the monochrome frame raster engine: random and directed row operations checked against a predictor.
`timescale 1ns / 1ps
module mono_frame_raster_ops_tb;

  localparam int unsigned NUM_RANDOM = 1600;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  mfr_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  mfr_pkg::out_t out_data_o;

  mono_frame_raster_ops u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  mfr_pkg::in_t  pending_reqs[$];
  mfr_pkg::out_t expected_results[$];
  logic [31:0]   shadow_frame[mfr_pkg::STORE_WORDS];
  int            error_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Sets or clears pixels lo..hi of one row, hi already clipped.
  function automatic void shadow_span(int unsigned row, int unsigned lo, int unsigned hi,
                                      bit set_bits);
    int unsigned a, b;
    logic [31:0] mask;
    if (lo > hi || row >= mfr_pkg::SCREEN_ROWS || hi >= mfr_pkg::ROW_PIXELS) return;
    for (int unsigned w = lo >> 5; w <= (hi >> 5); w++) begin
      a = (lo > w * 32) ? lo : w * 32;
      b = (hi < w * 32 + 31) ? hi : w * 32 + 31;
      mask = (32'hFFFF_FFFF >> (a % 32)) & (32'hFFFF_FFFF << (31 - (b % 32)));
      if (set_bits) shadow_frame[row * mfr_pkg::ROW_WORDS + w] |= mask;
      else shadow_frame[row * mfr_pkg::ROW_WORDS + w] &= ~mask;
    end
  endfunction

  function automatic void shadow_blit(int unsigned row, int unsigned x, logic [31:0] pat,
                                      int unsigned s);
    int unsigned w0;
    logic [63:0] v;
    w0 = x >> 5;
    if (row >= mfr_pkg::SCREEN_ROWS || w0 >= mfr_pkg::ROW_WORDS) return;
    v = {32'h0, pat} << (64 - s - (x % 32));
    shadow_frame[row * mfr_pkg::ROW_WORDS + w0] |= v[63:32];
    if (w0 + 1 < mfr_pkg::ROW_WORDS) shadow_frame[row * mfr_pkg::ROW_WORDS + w0 + 1] |= v[31:0];
  endfunction

  function automatic mfr_pkg::out_t raster_predict(mfr_pkg::in_t req);
    mfr_pkg::out_t res;
    int unsigned   x, y, wd, off, row, trow, s, ub, start, stop;
    logic [31:0]   m, pat;
    x = req.x_pos;
    y = req.y_pos;
    wd = req.span_width;
    off = req.row_offset;
    row = y + off;
    res = '0;
    if (req.req_type > mfr_pkg::REQ_READ) begin
      res.status = 1'b1;
    end else if (req.req_type == mfr_pkg::REQ_BLIT || req.req_type == mfr_pkg::REQ_BLIT_INV) begin
      s = (req.sprite_size == mfr_pkg::SZ_8) ? 8 : (req.sprite_size == mfr_pkg::SZ_16) ? 16 : 32;
      trow = (req.sprite_size == mfr_pkg::SZ_32) ? y + 2 * off : row;
      if (x >= mfr_pkg::ROW_PIXELS || y >= mfr_pkg::SCREEN_ROWS ||
          trow >= mfr_pkg::SCREEN_ROWS) begin
        res.status = 1'b1;
      end else if (req.sprite_size != mfr_pkg::SZ_UNUSED) begin
        m = (s == 32) ? 32'hFFFF_FFFF : ((32'd1 << s) - 1);
        pat = (req.req_type == mfr_pkg::REQ_BLIT_INV) ? (~req.sprite_bits & m) :
                                                        (req.sprite_bits & m);
        shadow_blit(trow, x, pat, s);
        if (req.sprite_size == mfr_pkg::SZ_32) shadow_blit(trow + 1, x, pat, s);
      end
    end else if (x >= mfr_pkg::ROW_PIXELS || y >= mfr_pkg::SCREEN_ROWS ||
                 row >= mfr_pkg::SCREEN_ROWS) begin
      res.status = 1'b1;
    end else if (req.req_type == mfr_pkg::REQ_FILL) begin
      if (wd != 0) begin
        stop = x + wd - 1;
        if (stop >= mfr_pkg::ROW_PIXELS) stop = mfr_pkg::ROW_PIXELS - 1;
        shadow_span(row, x, stop, 1'b1);
      end
    end else if (req.req_type == mfr_pkg::REQ_CLEAR) begin
      ub = (wd <= 8) ? 8 : (wd <= 32) ? 16 : 32;
      start = (x / ub) * ub;
      stop = start + (wd / ub + 1) * ub - 1;
      if (stop >= mfr_pkg::ROW_PIXELS) stop = mfr_pkg::ROW_PIXELS - 1;
      shadow_span(row, start, stop, 1'b0);
    end else if (req.req_type == mfr_pkg::REQ_SET) begin
      shadow_span(row, x, x, 1'b1);
    end else begin
      res.read_data = shadow_frame[row * mfr_pkg::ROW_WORDS + (x >> 5)];
    end
    return res;
  endfunction

  function automatic mfr_pkg::in_t make_req(logic [2:0] kind, int unsigned x, int unsigned y,
                                            int unsigned wd, int unsigned off, logic [1:0] sz,
                                            logic [31:0] bits);
    mfr_pkg::in_t r;
    r.req_type = kind;
    r.x_pos = x[9:0];
    r.y_pos = y[8:0];
    r.span_width = wd[9:0];
    r.row_offset = off[8:0];
    r.sprite_size = sz;
    r.sprite_bits = bits;
    return r;
  endfunction

  // Mostly on-screen operations on a few rows so that reads see earlier writes.
  function automatic mfr_pkg::in_t random_req();
    mfr_pkg::in_t r;
    logic [95:0]  raw;
    int           pick;
    raw = {$urandom, $urandom, $urandom};
    r = raw[74:0];
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      r.req_type = 3'($urandom_range(0, 5));
      if ($urandom_range(0, 4) == 0) r.req_type = mfr_pkg::REQ_READ;
      r.x_pos = 10'($urandom_range(0, mfr_pkg::ROW_PIXELS - 1));
      r.y_pos = 9'($urandom_range(0, 15));
      r.row_offset = 9'($urandom_range(0, 8));
      r.sprite_size = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 7) r.span_width = 10'($urandom_range(0, 48));
      else r.span_width = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 19) == 0) r.y_pos = 9'($urandom_range(380, 399));
    end else if (pick < 90) begin
      r.sprite_size = mfr_pkg::SZ_UNUSED;
    end
    return r;
  endfunction

  task automatic push_req(mfr_pkg::in_t r);
    pending_reqs.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) expected_results.push_back(raster_predict(in_data_i));
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no expectation waiting");
      end else begin
        automatic mfr_pkg::out_t exp_res = expected_results.pop_front();
        if (out_data_o.read_data !== exp_res.read_data)
          report_mismatch($sformatf("read_data got %h exp %h",
                                    out_data_o.read_data, exp_res.read_data));
        if (out_data_o.status !== exp_res.status)
          report_mismatch($sformatf("status got %b exp %b",
                                    out_data_o.status, exp_res.status));
      end
    end
  end

  // Receiver stall, with long hold-offs counted down here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    error_count = 0;
    send_idle_pct = 34;
    recv_idle_pct = 51;
    hold_cycles = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every operation, rejections and the odd encodings.
    push_req(make_req(mfr_pkg::REQ_READ, 639, 399, 1, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_FILL, 0, 0, 640, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_READ, 0, 0, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_READ, 639, 0, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_CLEAR, 5, 0, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_CLEAR, 40, 0, 20, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_CLEAR, 600, 0, 1023, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_READ, 0, 0, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_READ, 608, 0, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_FILL, 30, 1, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_FILL, 30, 1, 1023, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_BLIT, 28, 2, 0, 0, mfr_pkg::SZ_8, 32'hFFFF_FFA5));
    push_req(make_req(mfr_pkg::REQ_BLIT_INV, 636, 3, 0, 0, mfr_pkg::SZ_16, 32'h0000_1234));
    push_req(make_req(mfr_pkg::REQ_BLIT, 630, 200, 0, 199, mfr_pkg::SZ_32, 32'hDEAD_BEEF));
    push_req(make_req(mfr_pkg::REQ_BLIT, 10, 0, 0, 200, mfr_pkg::SZ_32, 32'h1));
    push_req(make_req(mfr_pkg::REQ_BLIT, 10, 4, 0, 0, mfr_pkg::SZ_UNUSED, 32'hFFFF_FFFF));
    push_req(make_req(mfr_pkg::REQ_SET, 639, 399, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_SET, 0, 0, 0, 399, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_READ, 639, 399, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_READ, 640, 0, 0, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_FILL, 0, 400, 1, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(mfr_pkg::REQ_SET, 0, 300, 1, 100, mfr_pkg::SZ_8, 0));
    push_req(make_req(3'd6, 0, 0, 1, 0, mfr_pkg::SZ_8, 0));
    push_req(make_req(3'd7, 1023, 511, 1023, 511, mfr_pkg::SZ_UNUSED, 32'hFFFF_FFFF));
    push_req(make_req(mfr_pkg::REQ_READ, 608, 399, 0, 0, mfr_pkg::SZ_8, 0));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        wait (pending_reqs.size() == 0);
        send_idle_pct = 51;
        recv_idle_pct = 34;
        // Long receiver hold-off while the sender keeps offering transfers.
        hold_cycles = 400;
      end
      if (i == 2 * NUM_RANDOM / 3) begin
        wait (pending_reqs.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      push_req(random_req());
    end

    wait (pending_reqs.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_front.sv
hw/rtl/mfr_queue.sv
hw/rtl/mfr_back.sv
hw/rtl/mono_frame_raster_ops.sv
sim/mono_frame_raster_ops_tb.sv
